/* rtl/rau_pkg.sv */
package rau_pkg;

    localparam int KIND_W    = 2;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 31;
    localparam int RES_NUM_W = 64;
    localparam int RES_DEN_W = 63;
    localparam int STATUS_W  = 2;

    localparam logic [RES_NUM_W-1:0] MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DIVZ = 2'd1,
        STATUS_OVF  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_COMB,
        ST_NEG,
        ST_ZCHK,
        ST_GCD,
        ST_GSHIFT,
        ST_DIVN,
        ST_DIVD,
        ST_FIN
    } state_t;

endpackage

/* rtl/rau_opnd_if.sv */
interface rau_opnd_if import rau_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [NUM_W-1:0] a_num;
    logic [DEN_W-1:0]        a_den;
    logic signed [NUM_W-1:0] b_num;
    logic [DEN_W-1:0]        b_den;

    modport source (
        output valid,
        output kind,
        output a_num,
        output a_den,
        output b_num,
        output b_den,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  a_num,
        input  a_den,
        input  b_num,
        input  b_den,
        output ready
    );

endinterface

/* rtl/rau_res_if.sv */
interface rau_res_if import rau_pkg::*; ();

    logic                        valid;
    logic                        ready;
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic [STATUS_W-1:0]         status;

    modport source (
        output valid,
        output res_num,
        output res_den,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  res_num,
        input  res_den,
        input  status,
        output ready
    );

endinterface

/* rtl/rational_arith_unit.sv */
// Channel   Role    Handshake      Payload
// opnd      sink    valid/ready    kind, a_num, a_den, b_num, b_den
// result    source  valid/ready    res_num, res_den, status
//
// One transaction at a time: opnd.ready is high only while the sequencer is idle.
// Steps: 2 or 3 multiplier steps, a binary gcd taking one shift, subtract or swap per
// cycle, then two restoring divisions of 2*OPERAND_BITS+1 quotient bits each; the
// gcd and the divisions share one adder/subtractor with the add/sub combine step.
// Zero denominators and divide by zero skip to ST_FIN, zero results after ST_ZCHK.
// Reset is asynchronous; no clearing pass. A stalled result register holds the
// finished sequencer, and the next transaction is accepted as soon as it is loaded.
module rational_arith_unit import rau_pkg::*; #(
    parameter int OPERAND_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    rau_opnd_if.sink   opnd,
    rau_res_if.source  result
);

    localparam int N      = OPERAND_BITS;
    localparam int PROD_W = 2 * N;
    localparam int W      = 2 * N + 1;
    localparam int AW     = W + 1;
    localparam int CNT_W  = $clog2(W + 1);
    localparam int EXT_W  = (W > RES_NUM_W) ? W : RES_NUM_W;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic                an_reg, an_next, bn_reg, bn_next;
    logic [N-1:0]        am_reg, am_next, bm_reg, bm_next;
    logic [N-2:0]        ad_reg, ad_next, bd_reg, bd_next;
    logic [PROD_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic [W-1:0]        mag_reg, mag_next, den_reg, den_next;
    logic [W-1:0]        u_reg, u_next, v_reg, v_next, rem_reg, rem_next;
    logic [CNT_W-1:0]    k_reg, k_next, cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    status_t             status_reg, status_next;

    logic                    res_valid_reg, res_valid_next;
    logic [RES_NUM_W-1:0]    res_num_reg, res_num_next;
    logic [RES_DEN_W-1:0]    res_den_reg, res_den_next;
    status_t                 res_status_reg, res_status_next;

    logic [N-1:0]        a_raw, b_raw, am_in, bm_in;
    logic [N-2:0]        ad_in, bd_in;
    logic                err_in;
    logic                add_type, yneg;

    logic [N-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;

    logic [AW-1:0]       alu_a, alu_b;
    logic                alu_sub;
    logic [AW:0]         alu_sum;
    logic                alu_carry;

    logic                res_load, qbit, last_bit;
    logic [W-1:0]        quot;
    logic [EXT_W-1:0]    mag_ext, den_ext;
    logic                ovf;
    status_t             fin_status;

    assign a_raw  = opnd.a_num[N-1:0];
    assign b_raw  = opnd.b_num[N-1:0];
    assign am_in  = a_raw[N-1] ? (-a_raw) : a_raw;
    assign bm_in  = b_raw[N-1] ? (-b_raw) : b_raw;
    assign ad_in  = opnd.a_den[N-2:0];
    assign bd_in  = opnd.b_den[N-2:0];
    assign err_in = (ad_in == '0) || (bd_in == '0)
                    || ((kind_t'(opnd.kind) == KIND_DIV) && (bm_in == '0));

    assign add_type = (kind_reg == KIND_ADD) || (kind_reg == KIND_SUB);
    assign yneg     = (kind_reg == KIND_SUB) ? !bn_reg : bn_reg;

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + (AW + 1)'(alu_sub);
    assign alu_carry = alu_sum[AW];

    assign qbit     = alu_carry;
    assign quot     = {u_reg[W-2:0], qbit};
    assign last_bit = (cnt_reg == CNT_W'(W - 1));

    assign mag_ext = EXT_W'(mag_reg);
    assign den_ext = EXT_W'(den_reg);
    assign ovf     = (mag_ext > EXT_W'(MAX_MAG)) || (den_ext > EXT_W'(MAX_MAG));
    assign fin_status = ((status_reg == STATUS_OK) && ovf) ? STATUS_OVF : status_reg;

    assign res_load = (state_reg == ST_FIN) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (opnd.valid)
                begin
                    state_next = err_in ? ST_FIN : ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = add_type ? ST_MUL3 : ST_COMB;
            end
            ST_MUL3:
            begin
                state_next = ST_COMB;
            end
            ST_COMB:
            begin
                if (add_type && (an_reg != yneg) && !alu_carry)
                begin
                    state_next = ST_NEG;
                end
                else
                begin
                    state_next = ST_ZCHK;
                end
            end
            ST_NEG:
            begin
                state_next = ST_ZCHK;
            end
            ST_ZCHK:
            begin
                state_next = (mag_reg == '0) ? ST_FIN : ST_GCD;
            end
            ST_GCD:
            begin
                if (u_reg == '0)
                begin
                    state_next = ST_GSHIFT;
                end
            end
            ST_GSHIFT:
            begin
                if (k_reg == '0)
                begin
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (last_bit)
                begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (last_bit)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        opnd.ready  = 1'b0;
        kind_next   = kind_reg;
        an_next     = an_reg;
        bn_next     = bn_reg;
        am_next     = am_reg;
        bm_next     = bm_reg;
        ad_next     = ad_reg;
        bd_next     = bd_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        mag_next    = mag_reg;
        den_next    = den_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        rem_next    = rem_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        status_next = status_reg;
        mul_a       = am_reg;
        mul_b       = bm_reg;
        alu_a       = AW'(u_reg);
        alu_b       = AW'(v_reg);
        alu_sub     = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                opnd.ready = 1'b1;
                if (opnd.valid)
                begin
                    kind_next   = kind_t'(opnd.kind);
                    an_next     = a_raw[N-1];
                    bn_next     = b_raw[N-1];
                    am_next     = am_in;
                    bm_next     = bm_in;
                    ad_next     = ad_in;
                    bd_next     = bd_in;
                    status_next = err_in ? STATUS_DIVZ : STATUS_OK;
                end
            end
            ST_MUL1:
            begin
                mul_a  = am_reg;
                mul_b  = (kind_reg == KIND_MUL) ? bm_reg : {1'b0, bd_reg};
                x_next = mul_p;
            end
            ST_MUL2:
            begin
                mul_a = {1'b0, ad_reg};
                mul_b = (kind_reg == KIND_MUL) ? {1'b0, bd_reg} : bm_reg;
                if (add_type)
                begin
                    y_next = mul_p;
                end
                else
                begin
                    den_next = W'(mul_p);
                end
            end
            ST_MUL3:
            begin
                mul_a    = {1'b0, ad_reg};
                mul_b    = {1'b0, bd_reg};
                den_next = W'(mul_p);
            end
            ST_COMB:
            begin
                alu_a   = AW'(x_reg);
                alu_b   = AW'(y_reg);
                alu_sub = add_type && (an_reg != yneg);
                if (!add_type)
                begin
                    mag_next = W'(x_reg);
                    neg_next = an_reg ^ bn_reg;
                end
                else if (!alu_sub || alu_carry)
                begin
                    mag_next = alu_sum[W-1:0];
                    neg_next = an_reg;
                end
            end
            ST_NEG:
            begin
                alu_a    = AW'(y_reg);
                alu_b    = AW'(x_reg);
                mag_next = alu_sum[W-1:0];
                neg_next = yneg;
            end
            ST_ZCHK:
            begin
                if (mag_reg == '0)
                begin
                    den_next = W'(1);
                    neg_next = 1'b0;
                end
                else
                begin
                    u_next = mag_reg;
                    v_next = den_reg;
                    k_next = '0;
                end
            end
            ST_GCD:
            begin
                if (u_reg != '0)
                begin
                    priority if (!u_reg[0] && !v_reg[0])
                    begin
                        u_next = u_reg >> 1;
                        v_next = v_reg >> 1;
                        k_next = k_reg + CNT_W'(1);
                    end
                    else if (!u_reg[0])
                    begin
                        u_next = u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_next = v_reg >> 1;
                    end
                    else if (alu_carry)
                    begin
                        u_next = alu_sum[W-1:0];
                    end
                    else
                    begin
                        u_next = v_reg;
                        v_next = u_reg;
                    end
                end
            end
            ST_GSHIFT:
            begin
                if (k_reg != '0)
                begin
                    v_next = {v_reg[W-2:0], 1'b0};
                    k_next = k_reg - CNT_W'(1);
                end
                else
                begin
                    u_next   = mag_reg;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            ST_DIVN, ST_DIVD:
            begin
                alu_a    = {rem_reg, u_reg[W-1]};
                alu_b    = {1'b0, v_reg};
                rem_next = qbit ? alu_sum[W-1:0] : alu_a[W-1:0];
                u_next   = quot;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_bit)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == ST_DIVN)
                    begin
                        mag_next = quot;
                        u_next   = den_reg;
                    end
                    else
                    begin
                        den_next = quot;
                    end
                end
            end
            ST_FIN:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_valid_next  = res_valid_reg && !result.ready;
        res_num_next    = res_num_reg;
        res_den_next    = res_den_reg;
        res_status_next = res_status_reg;
        if (res_load)
        begin
            res_valid_next  = 1'b1;
            res_status_next = fin_status;
            if (fin_status != STATUS_OK)
            begin
                res_num_next = '0;
                res_den_next = '0;
            end
            else
            begin
                res_num_next = neg_reg ? (-mag_ext[RES_NUM_W-1:0])
                                       : mag_ext[RES_NUM_W-1:0];
                res_den_next = den_ext[RES_DEN_W-1:0];
            end
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.res_num = res_num_reg;
    assign result.res_den = res_den_reg;
    assign result.status  = res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        an_reg         <= an_next;
        bn_reg         <= bn_next;
        am_reg         <= am_next;
        bm_reg         <= bm_next;
        ad_reg         <= ad_next;
        bd_reg         <= bd_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        mag_reg        <= mag_next;
        den_reg        <= den_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        rem_reg        <= rem_next;
        k_reg          <= k_next;
        cnt_reg        <= cnt_next;
        neg_reg        <= neg_next;
        status_reg     <= status_next;
        res_num_reg    <= res_num_next;
        res_den_reg    <= res_den_next;
        res_status_reg <= res_status_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        opnd.valid && opnd.ready |=> !opnd.ready)
        else $error("operand accepted while sequencer busy");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD) || (state_reg == ST_DIVN) || (state_reg == ST_DIVD)
        |-> v_reg != '0)
        else $error("gcd or divisor register is zero");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status != STATUS_OK)
        |-> (result.res_num == '0) && (result.res_den == '0))
        else $error("error result carries nonzero payload");

    a_ok_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == STATUS_OK) |-> result.res_den != '0)
        else $error("valid result with zero denominator");

    a_zero_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == STATUS_OK) && (result.res_num == '0)
        |-> result.res_den == RES_DEN_W'(1))
        else $error("zero result not reduced to 0/1");

endmodule

/* tb/tb_rational_arith_unit.sv */
`timescale 1ns / 100ps

module tb_rational_arith_unit;
    import rau_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int LATENCY      = 400;
    localparam int HOLD_CYCLES  = 1500;
    localparam int IDLE_PCT     = 31;

    typedef struct packed {
        logic [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0] den;
        status_t              status;
    } fraction_t;

    logic clk;
    logic rst_n;
    logic no_idle;
    logic hold_req;
    int   mismatch_count;

    fraction_t pending_fractions[$];

    rau_opnd_if opnd_ch ();
    rau_res_if  res_ch ();

    rational_arith_unit #(
        .OPERAND_BITS(NUM_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .opnd   (opnd_ch),
        .result (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 64'd0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic fraction_t reduced_fraction(kind_t k,
                                                   logic [NUM_W-1:0] an,
                                                   logic [DEN_W-1:0] ad,
                                                   logic [NUM_W-1:0] bn,
                                                   logic [DEN_W-1:0] bd);
        logic        neg_a;
        logic        neg_b;
        logic        neg_y;
        logic        neg_r;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] den_a;
        logic [63:0] den_b;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] g;
        logic [63:0] lcm;
        logic [63:0] x;
        logic [63:0] y;
        status_t     st;
        fraction_t   r;
        neg_a = an[NUM_W-1];
        neg_b = bn[NUM_W-1];
        mag_a = neg_a ? (64'h1_0000_0000 - {32'd0, an}) : {32'd0, an};
        mag_b = neg_b ? (64'h1_0000_0000 - {32'd0, bn}) : {32'd0, bn};
        den_a = {33'd0, ad};
        den_b = {33'd0, bd};
        mag   = 64'd0;
        den   = 64'd1;
        neg_r = 1'b0;
        st    = STATUS_OK;
        if (den_a == 64'd0 || den_b == 64'd0)
        begin
            st = STATUS_DIVZ;
        end
        else
        begin
            case (k)
                KIND_ADD, KIND_SUB:
                begin
                    g     = common_divisor(den_a, den_b);
                    lcm   = (den_a / g) * den_b;
                    x     = mag_a * (lcm / den_a);
                    y     = mag_b * (lcm / den_b);
                    neg_y = (k == KIND_SUB) ? !neg_b : neg_b;
                    if (neg_a == neg_y)
                    begin
                        mag   = x + y;
                        neg_r = neg_a;
                    end
                    else if (x >= y)
                    begin
                        mag   = x - y;
                        neg_r = neg_a;
                    end
                    else
                    begin
                        mag   = y - x;
                        neg_r = neg_y;
                    end
                    den = lcm;
                end
                KIND_MUL:
                begin
                    mag   = mag_a * mag_b;
                    den   = den_a * den_b;
                    neg_r = neg_a != neg_b;
                end
                default:
                begin
                    if (mag_b == 64'd0)
                    begin
                        st = STATUS_DIVZ;
                    end
                    else
                    begin
                        mag   = mag_a * den_b;
                        den   = den_a * mag_b;
                        neg_r = neg_a != neg_b;
                    end
                end
            endcase
        end
        if (st == STATUS_OK)
        begin
            g = common_divisor(mag, den);
            if (g != 64'd0)
            begin
                mag = mag / g;
                den = den / g;
            end
            if (mag == 64'd0)
            begin
                neg_r = 1'b0;
                den   = 64'd1;
            end
            if (mag > MAX_MAG || den > MAX_MAG)
            begin
                st = STATUS_OVF;
            end
        end
        if (st != STATUS_OK)
        begin
            r.num = '0;
            r.den = '0;
        end
        else
        begin
            r.num = neg_r ? (64'd0 - mag) : mag;
            r.den = den[RES_DEN_W-1:0];
        end
        r.status = st;
        return r;
    endfunction

    task automatic send_op(input kind_t k,
                           input logic [NUM_W-1:0] an,
                           input logic [DEN_W-1:0] ad,
                           input logic [NUM_W-1:0] bn,
                           input logic [DEN_W-1:0] bd);
        @(posedge clk);
        if (!no_idle)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, LATENCY)) @(posedge clk);
            end
            while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
        end
        opnd_ch.valid <= 1'b1;
        opnd_ch.kind  <= k;
        opnd_ch.a_num <= an;
        opnd_ch.a_den <= ad;
        opnd_ch.b_num <= bn;
        opnd_ch.b_den <= bd;
        do @(posedge clk); while (!opnd_ch.ready);
        pending_fractions = {pending_fractions, reduced_fraction(k, an, ad, bn, bd)};
        opnd_ch.valid <= 1'b0;
    endtask

    function automatic logic [NUM_W-1:0] pick_num();
        logic [NUM_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = NUM_W'($signed($urandom_range(0, 40)) - 20);
            4, 5, 6:    v = $urandom;
            7:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'd0;
                    default: v = 32'd1;
                endcase
            end
            default:
            begin
                v = $urandom_range(1, 1000) * $urandom_range(1, 1000);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [DEN_W-1:0] pick_den();
        logic [DEN_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = DEN_W'($urandom_range(1, 64));
            4, 5, 6:    v = DEN_W'($urandom);
            7:
            begin
                case ($urandom_range(0, 2))
                    0:       v = 31'h7FFF_FFFF;
                    1:       v = 31'h4000_0000;
                    default: v = 31'd1;
                endcase
            end
            8:          v = DEN_W'($urandom_range(1, 2000) * $urandom_range(1, 2000));
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    v = '0;
                end
                else
                begin
                    v = 31'd1 << $urandom_range(0, 30);
                end
            end
        endcase
        return v;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_op(kind_t'($urandom_range(0, 3)), pick_num(), pick_den(),
                    pick_num(), pick_den());
        end
    endtask

    task automatic test_directed();
        send_op(KIND_ADD, 1, 2, 1, 3);
        send_op(KIND_SUB, 1, 2, 1, 2);
        send_op(KIND_SUB, 1, 3, 1, 2);
        send_op(KIND_ADD, 32'hFFFF_FFFF, 6, 1, 6);
        send_op(KIND_SUB, 6, 4, 32'hFFFF_FFFF, 4);
        send_op(KIND_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
        send_op(KIND_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFE);
        send_op(KIND_SUB, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFE);
        send_op(KIND_MUL, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_op(KIND_MUL, 0, 5, 32'hFFFF_FFFF, 7);
        send_op(KIND_MUL, 32'hFFFF_FFFA, 4, 32'hFFFF_FFF7, 10);
        send_op(KIND_DIV, 3, 4, 0, 5);
        send_op(KIND_DIV, 32'h8000_0000, 1, 32'hFFFF_FFFF, 1);
        send_op(KIND_DIV, 32'h7FFF_FFFF, 1, 32'h8000_0000, 31'h7FFF_FFFF);
        send_op(KIND_DIV, 0, 3, 32'hFFFF_FFFE, 9);
        send_op(KIND_ADD, 5, 0, 1, 2);
        send_op(KIND_SUB, 1, 2, 5, 0);
        send_op(KIND_MUL, 7, 0, 3, 0);
        send_op(KIND_DIV, 1, 0, 0, 1);
        send_op(KIND_DIV, 1, 3, 2, 0);
    endtask

    task automatic test_random_mix();
        send_random(600);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_random(150);
        no_idle = 1'b0;
    endtask

    task automatic test_result_backpressure();
        hold_req = 1'b1;
        send_random(10);
        while (hold_req) @(posedge clk);
    endtask

    task automatic test_random_tail();
        send_random(160);
    endtask

    initial
    begin
        no_idle        = 1'b0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        rst_n          <= 1'b0;
        opnd_ch.valid  <= 1'b0;
        opnd_ch.kind   <= KIND_ADD;
        opnd_ch.a_num  <= '0;
        opnd_ch.a_den  <= '0;
        opnd_ch.b_num  <= '0;
        opnd_ch.b_den  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_mix();
        test_back_to_back();
        test_result_backpressure();
        test_random_tail();
        while (pending_fractions.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (mismatch_count == 0 && pending_fractions.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hold off the result channel on request, otherwise stall at random unless no_idle is set
    initial
    begin
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            res_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_results
        fraction_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_fractions.size() == 0)
            begin
                $display("%0t: unexpected transaction num=%0d den=%0d status=%0d",
                         $time, $signed(res_ch.res_num), res_ch.res_den, res_ch.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (res_ch.res_num !== want.num)
                begin
                    $display("%0t: res_num expected %0d actual %0d", $time,
                             $signed(want.num), $signed(res_ch.res_num));
                    mismatch_count++;
                end
                if (res_ch.res_den !== want.den)
                begin
                    $display("%0t: res_den expected %0d actual %0d", $time,
                             want.den, res_ch.res_den);
                    mismatch_count++;
                end
                if (res_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, res_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
